// ===== rtl/core/tgc_pkg.sv =====
// ----------------------------------------------------------------------------
// tgc_pkg
// Shared types and constants for the tap gesture classifier: channel
// payloads, register map and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package tgc_pkg;

   localparam int unsigned TIME_W  = 32;
   localparam int unsigned MS_W    = 16;
   localparam int unsigned ADDR_W  = 2;

   // register map
   localparam logic [ADDR_W-1:0] CSR_ENABLE   = 2'd0;
   localparam logic [ADDR_W-1:0] CSR_DTAP_WIN = 2'd1;
   localparam logic [ADDR_W-1:0] CSR_LONG_MS  = 2'd2;

   // register reset values
   localparam logic            ENABLE_RST   = 1'b1;
   localparam logic [MS_W-1:0] DTAP_WIN_RST = 16'd300;
   localparam logic [MS_W-1:0] LONG_MS_RST  = 16'd1000;

   typedef struct packed {
      logic              level;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic              changed;
      logic              pressed;
      logic              single_tap;
      logic [TIME_W-1:0] single_tap_time;
      logic              double_tap;
      logic              long_press;
   } rsp_type;

   typedef struct packed {
      logic            enable;
      logic [MS_W-1:0] double_tap_window_ms;
      logic [MS_W-1:0] long_press_ms;
   } cfg_type;

endpackage

`default_nettype wire

// ===== rtl/core/tgc_if.sv =====
// ----------------------------------------------------------------------------
// tgc_if
// Valid/ready channel interfaces: tick requests, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface tgc_req_if;
   logic             valid;
   logic             ready;
   tgc_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface tgc_rsp_if;
   logic             valid;
   logic             ready;
   tgc_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface tgc_csr_if;
   logic                          valid;
   logic                          ready;
   logic [tgc_pkg::ADDR_W-1:0]    addr;
   logic [tgc_pkg::MS_W-1:0]      wdata;

   modport source (output valid, output addr, output wdata, input ready);
   modport sink   (input valid, input addr, input wdata, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tgc_csr.sv =====
// ----------------------------------------------------------------------------
// tgc_csr
// Configuration register file: enable, double-tap window, long-press time.
// ----------------------------------------------------------------------------
`default_nettype none

module tgc_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        wr_en,
   input  wire logic [tgc_pkg::ADDR_W-1:0]  wr_addr,
   input  wire logic [tgc_pkg::MS_W-1:0]    wr_data,
   output tgc_pkg::cfg_type                 cfg
);

   tgc_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_addr)
            tgc_pkg::CSR_ENABLE:   cfg_in.enable               = wr_data[0];
            tgc_pkg::CSR_DTAP_WIN: cfg_in.double_tap_window_ms = wr_data;
            tgc_pkg::CSR_LONG_MS:  cfg_in.long_press_ms        = wr_data;
            default: ; // drop writes beyond the map
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable               <= tgc_pkg::ENABLE_RST;
         cfg_ff.double_tap_window_ms <= tgc_pkg::DTAP_WIN_RST;
         cfg_ff.long_press_ms        <= tgc_pkg::LONG_MS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/core/tgc_tracker.sv =====
// ----------------------------------------------------------------------------
// tgc_tracker
// Press state tracker: holds the gesture state and forms the result of the
// tick on offer; the state advances only when the tick is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tgc_tracker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             take,
   input  wire tgc_pkg::req_type req,
   input  wire tgc_pkg::cfg_type cfg,
   output tgc_pkg::rsp_type      rsp
);

   logic                       pressed_ff,     pressed_in;
   logic [tgc_pkg::TIME_W-1:0] change_time_ff, change_time_in;
   logic [tgc_pkg::TIME_W-1:0] press_time_ff,  press_time_in;
   logic                       awaiting_ff,    awaiting_in;
   logic                       long_done_ff,   long_done_in;

   logic [tgc_pkg::TIME_W-1:0] since_press;
   logic [tgc_pkg::TIME_W-1:0] since_change;
   logic                       in_window;
   logic                       held_long;

   assign since_press  = req.now_ms - press_time_ff;
   assign since_change = req.now_ms - change_time_ff;
   assign in_window    = since_press <=
                         {{(tgc_pkg::TIME_W-tgc_pkg::MS_W){1'b0}}, cfg.double_tap_window_ms};
   assign held_long    = since_change >=
                         {{(tgc_pkg::TIME_W-tgc_pkg::MS_W){1'b0}}, cfg.long_press_ms};

   always_comb begin
      pressed_in     = pressed_ff;
      change_time_in = change_time_ff;
      press_time_in  = press_time_ff;
      awaiting_in    = awaiting_ff;
      long_done_in   = long_done_ff;
      rsp            = '0;

      if (cfg.enable) begin
         if (req.level != pressed_ff) begin
            pressed_in     = req.level;
            change_time_in = req.now_ms;
            rsp.changed    = 1'b1;
            if (req.level) begin
               if (awaiting_ff && in_window) begin
                  rsp.double_tap = 1'b1;
                  awaiting_in    = 1'b0;
               end else begin
                  awaiting_in = 1'b1;
               end
               press_time_in = req.now_ms;
               long_done_in  = 1'b0;
            end else if (awaiting_ff && !in_window) begin
               rsp.single_tap      = 1'b1;
               rsp.single_tap_time = press_time_ff;
               awaiting_in         = 1'b0;
            end
         end else if (pressed_ff && !long_done_ff && held_long) begin
            long_done_in   = 1'b1;
            rsp.long_press = 1'b1;
         end
      end

      rsp.pressed = pressed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff     <= 1'b0;
         change_time_ff <= '0;
         press_time_ff  <= '0;
         awaiting_ff    <= 1'b0;
         long_done_ff   <= 1'b0;
      end else if (take) begin
         pressed_ff     <= pressed_in;
         change_time_ff <= change_time_in;
         press_time_ff  <= press_time_in;
         awaiting_ff    <= awaiting_in;
         long_done_ff   <= long_done_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/tap_gesture_classifier_top.sv =====
// ----------------------------------------------------------------------------
// tap_gesture_classifier_top
// Single / double / long press classifier for one touch input, one result
// beat for every tick beat.
// ----------------------------------------------------------------------------
//
//   channel    dir   handshake      payload
//   --------   ---   ------------   -------------------------------------------
//   req_chan   in    valid/ready    level, now_ms
//   rsp_chan   out   valid/ready    changed, pressed, single_tap,
//                                   single_tap_time, double_tap, long_press
//   csr_chan   in    valid/ready    addr (0 enable, 1 window, 2 long), wdata
//
// One tick beat per cycle sustained while rsp_chan is ready; its result beat
// appears in the cycle after acceptance, set by the single result register
// after the tracker logic. req_chan.ready is high whenever the result register
// is empty or being drained, so a stalled rsp_chan holds back new ticks but not
// one already done. csr_chan is always ready. reset is synchronous and active
// high; it clears the gesture state, empties the result register and restores
// register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module tap_gesture_classifier_top (
   input  wire logic   clock,
   input  wire logic   reset,
   tgc_req_if.sink     req_chan,
   tgc_rsp_if.source   rsp_chan,
   tgc_csr_if.sink     csr_chan
);

   tgc_pkg::cfg_type cfg;
   tgc_pkg::rsp_type rsp_next;
   tgc_pkg::rsp_type rsp_data_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             take;

   // configuration writes complete on every valid beat
   assign csr_chan.ready = 1'b1;

   tgc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (csr_chan.valid),
      .wr_addr (csr_chan.addr),
      .wr_data (csr_chan.wdata),
      .cfg     (cfg)
   );

   // accept a tick when the result slot is free or freeing this cycle
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign take           = req_chan.valid && req_chan.ready;

   tgc_tracker u_tracker (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .req   (req_chan.data),
      .cfg   (cfg),
      .rsp   (rsp_next)
   );

   // result slot: fill on accept, empty once drained with nothing behind it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload needs no reset; load only on accept so a stalled beat holds
   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // a taken tick always leaves a result beat behind it
   a_take_fills : assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_valid_ff)
      else $error("accepted tick left no result");

   // a press cannot be both the second tap and a release
   a_tap_excl : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.single_tap && rsp_data_ff.double_tap))
      else $error("single and double tap together");

   // long press only reported while held without a level change
   a_long_held : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.long_press) |->
         (rsp_data_ff.pressed && !rsp_data_ff.changed))
      else $error("long press without a steady hold");

   // single tap only on a release, and its stamp is zero otherwise
   a_single_release : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         (rsp_data_ff.single_tap ? (rsp_data_ff.changed && !rsp_data_ff.pressed)
                                 : (rsp_data_ff.single_tap_time == '0)))
      else $error("single tap stamp or edge wrong");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for tap_gesture_classifier_top. Tick beats go in on
// req_chan, and a cycle-level model of the press tracker predicts every result
// beat. Each beat on rsp_chan is checked field by field against the oldest
// prediction. Directed gestures come first: taps, double taps at the window
// edge, long presses, timestamp wrap, zero and full-scale register settings
// and the disabled block. Randomised press/release traffic follows under
// several idle and stall mixes, then a long result stall that backs up the
// input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD     = 4;
   localparam int RESET_CYCLES    = 7;
   localparam int CYCLE_LIMIT     = 200_000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int HOLD_OFF_CYCLES = 160;
   localparam int MAX_PRINTED     = 100;

   // index 3 fits the address field but maps to no register
   localparam logic [tgc_pkg::ADDR_W-1:0] CSR_SPARE = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tgc_req_if req_if();
   tgc_rsp_if rsp_if();
   tgc_csr_if csr_if();

   tap_gesture_classifier_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // -------------------------------------------------------------------------
   // Press tracker model: register copy and gesture state
   // -------------------------------------------------------------------------
   logic                       cfg_enable = tgc_pkg::ENABLE_RST;
   logic [tgc_pkg::MS_W-1:0]   cfg_win    = tgc_pkg::DTAP_WIN_RST;
   logic [tgc_pkg::MS_W-1:0]   cfg_long   = tgc_pkg::LONG_MS_RST;

   logic                       btn_down       = 1'b0;
   logic [tgc_pkg::TIME_W-1:0] last_change_ms = '0;
   logic [tgc_pkg::TIME_W-1:0] last_press_ms  = '0;
   logic                       await_second   = 1'b0;
   logic                       long_done      = 1'b0;

   tgc_pkg::rsp_type pending_results[$];

   // stimulus knobs and bookkeeping
   int unsigned                send_idle_pct  = 0;
   int unsigned                recv_stall_pct = 0;
   logic                       rsp_hold       = 1'b0;
   logic                       drive_level    = 1'b0;
   logic [tgc_pkg::TIME_W-1:0] clock_ms       = '0;
   int unsigned                mismatch_cnt   = 0;
   int unsigned                cycle_cnt      = 0;

   // Work out the result beat of one tick and advance the tracker state.
   // Time differences are 32-bit, so they wrap as the timestamp does.
   function automatic tgc_pkg::rsp_type predict_tick(input tgc_pkg::req_type tick);
      tgc_pkg::rsp_type           res;
      logic [tgc_pkg::TIME_W-1:0] since_press;
      logic [tgc_pkg::TIME_W-1:0] since_change;
      res          = '0;
      since_press  = tick.now_ms - last_press_ms;
      since_change = tick.now_ms - last_change_ms;
      if (cfg_enable) begin
         if (tick.level != btn_down) begin
            btn_down       = tick.level;
            last_change_ms = tick.now_ms;
            res.changed    = 1'b1;
            if (btn_down) begin
               // second press inside the window closes a double tap
               if (await_second && since_press <= {16'd0, cfg_win}) begin
                  res.double_tap = 1'b1;
                  await_second   = 1'b0;
               end else begin
                  await_second = 1'b1;
               end
               last_press_ms = tick.now_ms;
               long_done     = 1'b0;
            end else if (await_second && since_press > {16'd0, cfg_win}) begin
               // a release only turns into a single tap once the window is past
               res.single_tap      = 1'b1;
               res.single_tap_time = last_press_ms;
               await_second        = 1'b0;
            end
         end else if (btn_down && !long_done && since_change >= {16'd0, cfg_long}) begin
            long_done      = 1'b1;
            res.long_press = 1'b1;
         end
      end
      res.pressed = btn_down;
      return res;
   endfunction

   // Append one predicted beat behind those already expected.
   function automatic void queue_expected(input tgc_pkg::rsp_type res);
      pending_results = {pending_results, res};
   endfunction

   function automatic void apply_csr(input logic [tgc_pkg::ADDR_W-1:0] idx,
                                     input logic [tgc_pkg::MS_W-1:0] value);
      case (idx)
         tgc_pkg::CSR_ENABLE:   cfg_enable = value[0];
         tgc_pkg::CSR_DTAP_WIN: cfg_win    = value;
         tgc_pkg::CSR_LONG_MS:  cfg_long   = value;
         default: ;
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Checking
   // -------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_cnt++;
      if (mismatch_cnt <= MAX_PRINTED)
         $display("MISMATCH at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
   endtask

   task automatic check_field(input string name, input logic [tgc_pkg::TIME_W-1:0] got,
                              input logic [tgc_pkg::TIME_W-1:0] want);
      if (got !== want) report_mismatch(name, 64'(got), 64'(want));
   endtask

   task automatic compare_result(input tgc_pkg::rsp_type got, input tgc_pkg::rsp_type want);
      check_field("changed", 32'(got.changed), 32'(want.changed));
      check_field("pressed", 32'(got.pressed), 32'(want.pressed));
      check_field("single_tap", 32'(got.single_tap), 32'(want.single_tap));
      check_field("single_tap_time", got.single_tap_time, want.single_tap_time);
      check_field("double_tap", 32'(got.double_tap), 32'(want.double_tap));
      check_field("long_press", 32'(got.long_press), 32'(want.long_press));
   endtask

   // Sample every channel at the rising edge, before the block's own updates
   // land. Predict on each accepted tick beat, mirror each register write, and
   // match each accepted result beat against the oldest prediction.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            queue_expected(predict_tick(req_if.data));
         if (csr_if.valid && csr_if.ready)
            apply_csr(csr_if.addr, csr_if.wdata);
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0)
               report_mismatch("result beat with nothing expected",
                               64'(rsp_if.data), 64'd0);
            else
               compare_result(rsp_if.data, pending_results.pop_front());
         end
      end
   end

   // Receiver: stall at random at the falling edge; the hold-off overrides it.
   always @(negedge clock) begin
      rsp_if.ready = !rsp_hold && ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Watchdog: give up well beyond the slowest legal run.
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------

   // Offer one tick beat after a random idle gap and hold it until taken.
   // Valid stays high afterwards so that back-to-back beats need no bubble.
   task automatic send_tick(input logic lvl, input logic [tgc_pkg::TIME_W-1:0] stamp);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid       = 1'b1;
      req_if.data.level  = lvl;
      req_if.data.now_ms = stamp;
      drive_level        = lvl;
      clock_ms           = stamp;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // Drop valid and wait until every predicted beat has come back.
   // Each tick yields exactly one beat, so an empty queue means idle.
   task automatic wait_drained();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [tgc_pkg::ADDR_W-1:0] idx,
                            input logic [tgc_pkg::MS_W-1:0] value);
      @(negedge clock);
      csr_if.valid = 1'b1;
      csr_if.addr  = idx;
      csr_if.wdata = value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   // Window and long-press settings: the extremes, short ones, and anything.
   function automatic logic [tgc_pkg::MS_W-1:0] pick_ms();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return tgc_pkg::MS_W'($urandom_range(1, 64));
         3:       return tgc_pkg::MS_W'($urandom());
         default: return tgc_pkg::MS_W'($urandom_range(0, 1500));
      endcase
   endfunction

   // Step to the next timestamp, aiming at the window and long-press edges.
   function automatic logic [tgc_pkg::TIME_W-1:0] pick_delta();
      int unsigned win;
      int unsigned hold;
      win  = cfg_win;
      hold = cfg_long;
      case ($urandom_range(0, 15))
         0:          return '0;
         1, 2, 3, 4: return $urandom_range(0, win / 2 + 1);
         5:          return win;
         6:          return win + 1;
         7:          return (win == 0) ? 0 : win - 1;
         8:          return hold;
         9:          return hold + 1;
         10:         return (hold == 0) ? 0 : hold - 1;
         11:         return $urandom();  // jump anywhere, wrapping included
         default:    return $urandom_range(0, win + hold + 10);
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Reset settings: window 300 ms, long press 1000 ms.
   task automatic test_basic_gestures();
      send_tick(1'b0, 32'd0);      // idle level, nothing to report
      send_tick(1'b1, 32'd100);    // first press opens the window
      send_tick(1'b0, 32'd150);    // short release: no single tap
      send_tick(1'b1, 32'd400);    // exactly on the window edge: double tap
      send_tick(1'b1, 32'd1399);   // one short of the long-press time
      send_tick(1'b1, 32'd1400);   // long press
      send_tick(1'b1, 32'd1500);   // reported once only
      send_tick(1'b0, 32'd1600);   // release with nothing awaited
      send_tick(1'b1, 32'd2000);   // fresh press
      send_tick(1'b0, 32'd2301);   // released past the window: single tap
   endtask

   // Gaps measured across the 32-bit rollover.
   task automatic test_timestamp_wrap();
      send_tick(1'b1, 32'hFFFF_FF00);
      send_tick(1'b0, 32'hFFFF_FFFF);
      send_tick(1'b1, 32'h0000_002B);   // 299 ms after the last press
      send_tick(1'b0, 32'h0000_0100);
   endtask

   task automatic test_register_extremes();
      // zero window and zero long-press time
      wait_drained();
      write_csr(tgc_pkg::CSR_LONG_MS, '0);
      write_csr(tgc_pkg::CSR_DTAP_WIN, '0);
      send_tick(1'b1, 32'd5000);
      send_tick(1'b1, 32'd5000);   // held into the next tick: long press at once
      send_tick(1'b0, 32'd5000);
      send_tick(1'b1, 32'd5000);   // zero gap still counts as double
      send_tick(1'b0, 32'd5001);

      // full-scale settings; a write to the spare index must change nothing
      wait_drained();
      write_csr(tgc_pkg::CSR_LONG_MS, '1);
      write_csr(tgc_pkg::CSR_DTAP_WIN, '1);
      write_csr(CSR_SPARE, tgc_pkg::MS_W'($urandom()));
      send_tick(1'b1, 32'd6000);
      send_tick(1'b1, 32'd6000 + 32'd65534);
      send_tick(1'b1, 32'd6000 + 32'd65535);
      send_tick(1'b0, 32'd6000 + 32'd65536);
   endtask

   // While disabled the state is frozen and only the held level shows.
   task automatic test_disabled_block();
      send_tick(1'b1, 32'd79000);
      wait_drained();
      write_csr(tgc_pkg::CSR_ENABLE, '0);
      send_tick(1'b1, 32'd149000);   // would be a long press if enabled
      send_tick(1'b0, 32'd149001);
      send_tick(1'b1, 32'd149002);
      wait_drained();
      write_csr(tgc_pkg::CSR_ENABLE, tgc_pkg::MS_W'(tgc_pkg::ENABLE_RST));
      write_csr(tgc_pkg::CSR_DTAP_WIN, tgc_pkg::DTAP_WIN_RST);
      write_csr(tgc_pkg::CSR_LONG_MS, tgc_pkg::LONG_MS_RST);
      send_tick(1'b1, 32'd149003);   // the held press now reports long
   endtask

   // Press/release random walk under each idle mix, reprogrammed regularly.
   task automatic test_random_traffic();
      int unsigned idle_send[4] = '{0, 53, 0, 22};
      int unsigned idle_recv[4] = '{0, 0, 53, 22};
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = idle_send[phase];
         recv_stall_pct = idle_recv[phase];
         for (int n = 0; n < 176; n++) begin
            if (n % 44 == 0) begin
               wait_drained();
               write_csr(tgc_pkg::CSR_DTAP_WIN, pick_ms());
               write_csr(tgc_pkg::CSR_LONG_MS, pick_ms());
               // upper bits are junk the register must drop; mostly enabled
               write_csr(tgc_pkg::CSR_ENABLE,
                         {15'($urandom()), 1'($urandom_range(0, 9) != 0)});
            end
            send_tick(($urandom_range(0, 99) < 45) ? ~drive_level : drive_level,
                      clock_ms + pick_delta());
         end
      end
   endtask

   // Hold the result side off for a long stretch while ticks keep coming,
   // so the result register fills and the input stalls behind it.
   task automatic test_input_backpressure();
      wait_drained();
      write_csr(tgc_pkg::CSR_ENABLE, tgc_pkg::MS_W'(tgc_pkg::ENABLE_RST));
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      fork
         begin
            @(posedge clock);
            rsp_hold = 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_hold = 1'b0;
         end
         for (int n = 0; n < 24; n++)
            send_tick(($urandom_range(0, 99) < 45) ? ~drive_level : drive_level,
                      clock_ms + pick_delta());
      join
   endtask

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------
   initial begin
      req_if.valid  = 1'b0;
      req_if.data   = '0;
      rsp_if.ready  = 1'b0;
      csr_if.valid  = 1'b0;
      csr_if.addr   = '0;
      csr_if.wdata  = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_basic_gestures();
      test_timestamp_wrap();
      test_register_extremes();
      test_disabled_block();
      test_random_traffic();
      test_input_backpressure();

      // let the last beats out, then wait DRAIN_CYCLES longer for stragglers
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_cnt == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== tap_gesture_classifier_top.f =====
rtl/core/tgc_pkg.sv
rtl/core/tgc_if.sv
rtl/core/tgc_csr.sv
rtl/core/tgc_tracker.sv
rtl/core/tap_gesture_classifier_top.sv
dv/tb_top.sv
